// ===== hw/rtl/cbpe_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Cubic Bezier point evaluator package
// Default widths shared by the top level and the per-axis datapath.
// ----------------------------------------------------------------------------
package cbpe_pkg;

    localparam int COORD_BITS_DEF      = 16;
    localparam int PARAM_FRAC_BITS_DEF = 16;

endpackage
`default_nettype wire

// ===== hw/rtl/cubic_bezier_point_eval.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Cubic Bezier point evaluator
// Evaluates B(t) = u^3 P0 + 3u^2 t P1 + 3u t^2 P2 + t^3 P3, u = 1 - t, for x
// and y at full precision and rounds each coordinate to nearest.
//
// The slave channel takes one item per cycle while o_s_tready is high: eight
// signed control point coordinates and the parameter t in Q1.16, where values
// above one are clamped to one. The master channel returns one item per
// accepted item, the curve point x and y, in the order of acceptance.
// The datapath is four register stages deep: clamp and squares, cubic
// weights, coordinate products, pairwise sums. The rounded point lands in an
// output register that drives o_m_tvalid and o_m_tdata.
// Throughput is one item per cycle while the receiver keeps i_m_tready high.
// When the receiver stalls, a one-entry skid register catches the item still
// coming out of the pipeline and o_s_tready drops until it drains; no item is
// lost or repeated. o_s_tready is driven straight from a register.
// Reset clears every valid bit; items in flight are dropped.
// ----------------------------------------------------------------------------
module cubic_bezier_point_eval
    import cbpe_pkg::*;
#(
    parameter int COORD_BITS      = COORD_BITS_DEF,
    parameter int PARAM_FRAC_BITS = PARAM_FRAC_BITS_DEF,
    localparam int T_W   = PARAM_FRAC_BITS + 1,
    localparam int IN_W  = ((8 * COORD_BITS + T_W + 7) / 8) * 8,
    localparam int OUT_W = ((2 * COORD_BITS + 7) / 8) * 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_s_tvalid,
    output logic                  o_s_tready,
    // ctrl0_x, ctrl0_y, ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y, ctrl3_x, ctrl3_y,
    // param_t, zero padding
    input  wire logic [IN_W-1:0]  i_s_tdata,
    output logic                  o_m_tvalid,
    input  wire logic             i_m_tready,
    // curve_x, curve_y, zero padding
    output logic [OUT_W-1:0]      o_m_tdata
);

    localparam int TT_W = 2 * T_W;
    localparam int T3_W = 3 * T_W;
    localparam int FRAC = 3 * PARAM_FRAC_BITS;
    localparam int W_W  = FRAC + 1;
    localparam logic [T_W-1:0] ONE     = T_W'(1) << PARAM_FRAC_BITS;
    localparam logic [W_W-1:0] W_TOTAL = W_W'(1) << FRAC;

    logic en;
    logic in_take;
    logic out_take;

    logic r_v1, r_v2, r_v3, r_v4;
    logic r_out_v, r_skid_v;

    logic [T_W-1:0]  n_t, n_u;
    logic [T_W-1:0]  r_t, r_u;
    logic [TT_W-1:0] r_t2, r_u2, r_ut;
    logic signed [COORD_BITS-1:0] r_c1 [8];
    logic signed [COORD_BITS-1:0] r_c2 [8];

    logic [T3_W-1:0] n_p0, n_p1, n_p2, n_p3;
    logic [W_W-1:0]  r_w0, r_w1, r_w2, r_w3;

    logic signed [COORD_BITS-1:0] res_x, res_y;
    logic signed [COORD_BITS-1:0] r_out_x, r_out_y;
    logic signed [COORD_BITS-1:0] r_skid_x, r_skid_y;

    assign en         = !r_skid_v;
    assign o_s_tready = en;
    assign in_take    = i_s_tvalid && en;
    assign out_take   = r_out_v && i_m_tready;
    assign o_m_tvalid = r_out_v;
    assign o_m_tdata  = OUT_W'({r_out_y, r_out_x});

    always_comb begin
        n_t  = (i_s_tdata[8*COORD_BITS +: T_W] > ONE) ? ONE
                                                       : i_s_tdata[8*COORD_BITS +: T_W];
        n_u  = ONE - n_t;
        n_p0 = T3_W'(r_u2) * T3_W'(r_u);
        n_p1 = T3_W'(r_u2) * T3_W'(r_t);
        n_p2 = T3_W'(r_ut) * T3_W'(r_t);
        n_p3 = T3_W'(r_t2) * T3_W'(r_t);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_t  <= n_t;
            r_u  <= n_u;
            r_t2 <= TT_W'(n_t) * TT_W'(n_t);
            r_u2 <= TT_W'(n_u) * TT_W'(n_u);
            r_ut <= TT_W'(n_u) * TT_W'(n_t);
            for (int k = 0; k < 8; k++) begin
                r_c1[k] <= i_s_tdata[k*COORD_BITS +: COORD_BITS];
                r_c2[k] <= r_c1[k];
            end
            r_w0 <= W_W'(n_p0);
            r_w1 <= W_W'(n_p1 + (n_p1 << 1));
            r_w2 <= W_W'(n_p2 + (n_p2 << 1));
            r_w3 <= W_W'(n_p3);
        end
    end

    cbpe_axis #(
        .COORD_BITS      (COORD_BITS),
        .PARAM_FRAC_BITS (PARAM_FRAC_BITS)
    ) u_axis_x (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_c0     (r_c2[0]),
        .i_c1     (r_c2[2]),
        .i_c2     (r_c2[4]),
        .i_c3     (r_c2[6]),
        .i_w0     (r_w0),
        .i_w1     (r_w1),
        .i_w2     (r_w2),
        .i_w3     (r_w3),
        .o_result (res_x)
    );

    cbpe_axis #(
        .COORD_BITS      (COORD_BITS),
        .PARAM_FRAC_BITS (PARAM_FRAC_BITS)
    ) u_axis_y (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_c0     (r_c2[1]),
        .i_c1     (r_c2[3]),
        .i_c2     (r_c2[5]),
        .i_c3     (r_c2[7]),
        .i_w0     (r_w0),
        .i_w1     (r_w1),
        .i_w2     (r_w2),
        .i_w3     (r_w3),
        .o_result (res_y)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
            r_v3     <= 1'b0;
            r_v4     <= 1'b0;
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            if (en) begin
                r_v1 <= in_take;
                r_v2 <= r_v1;
                r_v3 <= r_v2;
                r_v4 <= r_v3;
            end
            if (r_skid_v) begin
                if (out_take) begin
                    r_out_v  <= 1'b1;
                    r_skid_v <= 1'b0;
                end
            end else if (!r_out_v || out_take) begin
                r_out_v <= r_v4;
            end else if (r_v4) begin
                r_skid_v <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (out_take) begin
                r_out_x <= r_skid_x;
                r_out_y <= r_skid_y;
            end
        end else if (!r_out_v || out_take) begin
            r_out_x <= res_x;
            r_out_y <= res_y;
        end else begin
            r_skid_x <= res_x;
            r_skid_y <= res_y;
        end
    end

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid register holds an item while the output register is empty");

    a_skid_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_v) |-> $past(r_out_v && !i_m_tready && r_v4))
        else $error("skid register filled without a stalled output");

    a_t_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 |-> (r_t <= ONE) && (W_W'(r_t) + W_W'(r_u) == W_W'(ONE)))
        else $error("clamped parameter and its complement do not sum to one");

    a_weights_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 |-> ((W_W + 2)'(r_w0) + (W_W + 2)'(r_w1) + (W_W + 2)'(r_w2)
                  + (W_W + 2)'(r_w3) == (W_W + 2)'(W_TOTAL)))
        else $error("Bernstein weights do not sum to one");

endmodule
`default_nettype wire

// ===== hw/rtl/cbpe_axis.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Cubic Bezier axis datapath
// Multiplies four coordinates by their Bernstein weights, adds the products
// pairwise into registers and rounds their sum to the nearest coordinate step.
// ----------------------------------------------------------------------------
module cbpe_axis
    import cbpe_pkg::*;
#(
    parameter int COORD_BITS      = COORD_BITS_DEF,
    parameter int PARAM_FRAC_BITS = PARAM_FRAC_BITS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_en,
    input  wire logic signed [COORD_BITS-1:0]      i_c0,
    input  wire logic signed [COORD_BITS-1:0]      i_c1,
    input  wire logic signed [COORD_BITS-1:0]      i_c2,
    input  wire logic signed [COORD_BITS-1:0]      i_c3,
    input  wire logic [3*PARAM_FRAC_BITS:0]        i_w0,
    input  wire logic [3*PARAM_FRAC_BITS:0]        i_w1,
    input  wire logic [3*PARAM_FRAC_BITS:0]        i_w2,
    input  wire logic [3*PARAM_FRAC_BITS:0]        i_w3,
    output logic signed [COORD_BITS-1:0]           o_result
);

    localparam int FRAC   = 3 * PARAM_FRAC_BITS;
    localparam int W_W    = FRAC + 1;
    localparam int PROD_W = COORD_BITS + W_W + 1;
    localparam int ACC_W  = PROD_W + 1;
    localparam int SUM_W  = ACC_W + 1;
    localparam logic signed [SUM_W-1:0] HALF = SUM_W'(1) <<< (FRAC - 1);

    logic signed [PROD_W-1:0] r_p0, r_p1, r_p2, r_p3;
    logic signed [ACC_W-1:0]  r_s01, r_s23;
    logic signed [SUM_W-1:0]  total;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p0  <= i_c0 * $signed({1'b0, i_w0});
            r_p1  <= i_c1 * $signed({1'b0, i_w1});
            r_p2  <= i_c2 * $signed({1'b0, i_w2});
            r_p3  <= i_c3 * $signed({1'b0, i_w3});
            r_s01 <= ACC_W'(r_p0) + ACC_W'(r_p1);
            r_s23 <= ACC_W'(r_p2) + ACC_W'(r_p3);
        end
    end

    always_comb begin
        total    = SUM_W'(r_s01) + SUM_W'(r_s23) + HALF;
        o_result = total[FRAC +: COORD_BITS];
    end

endmodule
`default_nettype wire

// ===== test/cbpe_point_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cubic Bezier point checker
// Watches both stream channels of the evaluator. Each accepted input item is
// turned into the expected curve point by an exact Bernstein sum that is
// rounded half up. Each accepted result is compared, field by field, with the
// oldest expected point.
// ----------------------------------------------------------------------------
module cbpe_point_checker
    import cbpe_pkg::*;
#(
    parameter int IN_W  = 152,
    parameter int OUT_W = 32
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_s_tvalid,
    input  wire logic             i_s_tready,
    input  wire logic [IN_W-1:0]  i_s_tdata,
    input  wire logic             i_m_tvalid,
    input  wire logic             i_m_tready,
    input  wire logic [OUT_W-1:0] i_m_tdata,
    output int                    o_fail_count,
    output int                    o_pending,
    output int                    o_items,
    output int                    o_points,
    output int                    o_clamped
);

    localparam int CW        = COORD_BITS_DEF;
    localparam int TW        = PARAM_FRAC_BITS_DEF + 1;
    localparam int FRAC      = 3 * PARAM_FRAC_BITS_DEF;
    localparam int MISS_SHOW = 10;
    localparam logic [TW-1:0] T_ONE = TW'(1) << PARAM_FRAC_BITS_DEF;

    logic [2*CW-1:0] expected_points[$];
    int fails     = 0;
    int items     = 0;
    int points    = 0;
    int clamped   = 0;

    // Exact weighted sum of one axis; t above one is clamped to one.
    function automatic logic [CW-1:0] axis_point(input logic [CW-1:0] c0, input logic [CW-1:0] c1,
                                                 input logic [CW-1:0] c2, input logic [CW-1:0] c3,
                                                 input logic [TW-1:0] t);
        logic [TW-1:0]     tc;
        logic signed [95:0] ts;
        logic signed [95:0] us;
        logic signed [95:0] p0;
        logic signed [95:0] p1;
        logic signed [95:0] p2;
        logic signed [95:0] p3;
        logic signed [95:0] acc;
        tc  = (t > T_ONE) ? T_ONE : t;
        ts  = {{(96-TW){1'b0}}, tc};
        us  = {{(96-TW){1'b0}}, T_ONE} - ts;
        p0  = {{(96-CW){c0[CW-1]}}, c0};
        p1  = {{(96-CW){c1[CW-1]}}, c1};
        p2  = {{(96-CW){c2[CW-1]}}, c2};
        p3  = {{(96-CW){c3[CW-1]}}, c3};
        acc = p0 * us * us * us
            + 96'sd3 * p1 * us * us * ts
            + 96'sd3 * p2 * us * ts * ts
            + p3 * ts * ts * ts
            + (96'sd1 <<< (FRAC - 1));
        return acc[FRAC +: CW];
    endfunction

    always @(posedge i_clk) begin
        logic [2*CW-1:0] want;
        logic [CW-1:0]   px;
        logic [CW-1:0]   py;
        logic [TW-1:0]   t;
        if (i_rst_n) begin
            if (i_s_tvalid && i_s_tready) begin
                t  = i_s_tdata[8*CW +: TW];
                px = axis_point(i_s_tdata[0*CW +: CW], i_s_tdata[2*CW +: CW],
                                i_s_tdata[4*CW +: CW], i_s_tdata[6*CW +: CW], t);
                py = axis_point(i_s_tdata[1*CW +: CW], i_s_tdata[3*CW +: CW],
                                i_s_tdata[5*CW +: CW], i_s_tdata[7*CW +: CW], t);
                expected_points.push_back({py, px});
                items++;
                if (t > T_ONE) begin
                    clamped++;
                end
            end
            if (i_m_tvalid && i_m_tready) begin
                if (expected_points.size() == 0) begin
                    fails++;
                    if (fails <= MISS_SHOW) begin
                        $display("%0t: curve point %h arrived with none pending",
                                 $realtime, i_m_tdata);
                    end
                end else begin
                    want = expected_points.pop_front();
                    if (i_m_tdata[0 +: CW] !== want[0 +: CW]) begin
                        fails++;
                        if (fails <= MISS_SHOW) begin
                            $display("%0t: point %0d curve_x expected %h, got %h", $realtime,
                                     points, want[0 +: CW], i_m_tdata[0 +: CW]);
                        end
                    end
                    if (i_m_tdata[CW +: CW] !== want[CW +: CW]) begin
                        fails++;
                        if (fails <= MISS_SHOW) begin
                            $display("%0t: point %0d curve_y expected %h, got %h", $realtime,
                                     points, want[CW +: CW], i_m_tdata[CW +: CW]);
                        end
                    end
                    if ((i_m_tdata >> (2 * CW)) !== '0) begin
                        fails++;
                        if (fails <= MISS_SHOW) begin
                            $display("%0t: point %0d padding bits not zero: %h", $realtime,
                                     points, i_m_tdata);
                        end
                    end
                end
                points++;
            end
        end
        o_fail_count <= fails;
        o_pending    <= expected_points.size();
        o_items      <= items;
        o_points     <= points;
        o_clamped    <= clamped;
    end

endmodule

// ===== test/cubic_bezier_point_eval_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cubic Bezier point evaluator testbench
// Drives directed corner items and then random control points and curve
// parameters through four flow-control phases, pausing after each one until
// every point has come back. A separate checker predicts and compares.
// ----------------------------------------------------------------------------
module cubic_bezier_point_eval_tb;
    import cbpe_pkg::*;

    localparam int CW    = COORD_BITS_DEF;
    localparam int TW    = PARAM_FRAC_BITS_DEF + 1;
    localparam int IN_W  = ((8 * CW + TW + 7) / 8) * 8;
    localparam int OUT_W = ((2 * CW + 7) / 8) * 8;
    localparam int PHASE_ITEMS = 485;
    localparam logic [TW-1:0] T_ONE  = TW'(1) << PARAM_FRAC_BITS_DEF;
    localparam logic [TW-1:0] T_HALF = T_ONE >> 1;
    localparam logic [TW-1:0] T_MAX  = '1;
    localparam logic [CW-1:0] C_MIN  = {1'b1, {(CW-1){1'b0}}};
    localparam logic [CW-1:0] C_MAX  = {1'b0, {(CW-1){1'b1}}};

    logic             i_clk      = 1'b0;
    logic             i_rst_n    = 1'b0;
    logic             s_tvalid   = 1'b0;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata    = '0;
    logic             m_tvalid;
    logic             m_tready   = 1'b0;
    logic [OUT_W-1:0] m_tdata;

    int fail_count;
    int pending;
    int items;
    int points;
    int clamped;
    int idle_pct  = 0;
    int stall_pct = 0;

    cubic_bezier_point_eval i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    cbpe_point_checker #(
        .IN_W  (IN_W),
        .OUT_W (OUT_W)
    ) i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_items      (items),
        .o_points     (points),
        .o_clamped    (clamped)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Coordinate vectors list the points from the end point down to the start point.
    task automatic send_point(input logic [3:0][CW-1:0] cx, input logic [3:0][CW-1:0] cy,
                              input logic [TW-1:0] t);
        logic [IN_W-1:0] word;
        word = '0;
        for (int i = 0; i < 4; i++) begin
            word[2*i*CW +: CW]     = cx[i];
            word[(2*i+1)*CW +: CW] = cy[i];
        end
        word[8*CW +: TW] = t;
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            s_tdata  <= IN_W'({$urandom, $urandom, $urandom, $urandom, $urandom});
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
    endtask

    task automatic drain_points();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic run_random(input int count);
        logic [3:0][CW-1:0] cx;
        logic [3:0][CW-1:0] cy;
        logic [TW-1:0]      t;
        for (int n = 0; n < count; n++) begin
            for (int i = 0; i < 4; i++) begin
                for (int k = 0; k < 2; k++) begin
                    logic [CW-1:0] c;
                    case ($urandom_range(9))
                        0: c = C_MIN;
                        1: c = C_MAX;
                        2, 3, 4: c = CW'($urandom_range(64) - 32);
                        default: c = CW'($urandom);
                    endcase
                    if (k == 0) begin
                        cx[i] = c;
                    end else begin
                        cy[i] = c;
                    end
                end
            end
            case ($urandom_range(19))
                0: t = '0;
                1: t = T_ONE;
                2, 3: t = TW'($urandom_range(T_MAX, T_ONE + 1));
                default: t = TW'($urandom_range(T_ONE, 0));
            endcase
            send_point(cx, cy, t);
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_point('0, '0, '0);
        send_point({4{C_MAX}}, {4{C_MIN}}, TW'(12345));
        send_point({4{C_MIN}}, {4{C_MAX}}, T_ONE);
        send_point({C_MIN, C_MAX, C_MIN, C_MAX}, {C_MAX, C_MIN, C_MAX, C_MIN}, '0);
        send_point({C_MIN, C_MAX, C_MIN, C_MAX}, {C_MAX, C_MIN, C_MAX, C_MIN}, T_ONE);
        send_point({16'h1234, 16'h8765, 16'h0f0f, 16'hf0f0}, {16'h4321, 16'h5678, 16'h00ff,
                   16'hff00}, T_ONE + 1);
        send_point({16'h1234, 16'h8765, 16'h0f0f, 16'hf0f0}, {16'h4321, 16'h5678, 16'h00ff,
                   16'hff00}, T_MAX);
        send_point({C_MAX, C_MIN, C_MAX, C_MIN}, {C_MIN, C_MIN, C_MAX, C_MAX}, TW'(1));
        send_point({C_MAX, C_MIN, C_MAX, C_MIN}, {C_MIN, C_MIN, C_MAX, C_MAX}, T_ONE - 1);
        send_point({C_MAX, C_MAX, C_MIN, C_MIN}, {C_MIN, C_MIN, C_MAX, C_MAX}, T_HALF);
        // Exact halves at t = 0.5: ties round toward plus infinity.
        send_point({16'd0, 16'd0, 16'd0, 16'd4}, {16'd0, 16'd0, 16'd0, -16'sd4}, T_HALF);
        send_point({16'd4, 16'd0, 16'd0, 16'd0}, {-16'sd4, 16'd0, 16'd0, 16'd0}, T_HALF);
        send_point({16'd0, 16'd0, 16'd4, 16'd0}, {16'd0, 16'd0, -16'sd4, 16'd0}, T_HALF);
        send_point({16'd0, 16'd4, 16'd0, 16'd0}, {16'd0, -16'sd12, 16'd0, 16'd0}, T_HALF);
        send_point({4{16'hffff}}, {4{16'h0001}}, TW'(21845));
        drain_points();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 63; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 63; end
                default: begin idle_pct = 31; stall_pct = 31; end
            endcase
            run_random(PHASE_ITEMS);
            drain_points();
        end

        stall_pct = 0;
        repeat (20) @(posedge i_clk);
        $display("Sent %0d items (%0d with t clamped to one), checked %0d curve points.",
                 items, clamped, points);
        $display("Covered corner points, rounding ties, sender gaps and receiver stalls.");
        if (fail_count == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("Timeout with %0d curve points still pending.", pending);
        $display("*** FAILED ***");
        $finish;
    end

endmodule
